// ===== rtl/core/tfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radar TLV frame parser package
// Types, codes and constants that the parser modules share.
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

  typedef enum logic [2:0] {
    PH_SYNC,
    PH_HEADER,
    PH_SECHDR,
    PH_POINT,
    PH_SIDE,
    PH_SKIP,
    PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HDR_A     = 3'd0,
    KIND_HDR_B     = 3'd1,
    KIND_POINT     = 3'd2,
    KIND_SIDE      = 3'd3,
    KIND_UNKNOWN   = 3'd4,
    KIND_BAD_SYNC  = 3'd5,
    KIND_FRAME_END = 3'd6
  } kind_t;

  localparam logic [63:0] SYNC_WORD_RESET = 64'h0708_0506_0304_0102;

  localparam logic [31:0] SEC_POINTS    = 32'd1;
  localparam logic [31:0] SEC_SIDE_INFO = 32'd7;
  localparam logic [31:0] SEC_SKIP_A    = 32'd2;
  localparam logic [31:0] SEC_SKIP_B    = 32'd3;
  localparam logic [31:0] SEC_SKIP_C    = 32'd4;

  localparam logic [2:0] WORD_LAST_BYTE  = 3'd3;
  localparam logic [2:0] DWORD_LAST_BYTE = 3'd7;
  localparam logic [3:0] HDR_LAST_WORD   = 4'd7;
  localparam logic [3:0] POINT_LAST_WORD = 4'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] item_index;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic        last_in_frame;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/tfp_if.sv =====
// ----------------------------------------------------------------------------
// Radar TLV frame parser channels
// Valid/ready channels for received bytes and for parsed result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink (input valid, data_byte, frame_start, output ready);
endinterface

interface tfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] item_index;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;
  logic        last_in_frame;

  modport source (output valid, kind, item_index, word_a, word_b, word_c, word_d,
                  last_in_frame, input ready);
  modport sink (input valid, kind, item_index, word_a, word_b, word_c, word_d,
                last_in_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tfp_front.sv =====
// ----------------------------------------------------------------------------
// Radar TLV frame parser front end
// Takes one byte per cycle when in_acc is high, walks sync, header and
// sections, and pushes any result word it produces into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_front
  import tfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_start,
  input  wire logic        in_acc,
  output push_t            push
);

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [2:0]  bp_r, bp_nxt, bp_eff;
  logic [3:0]  hw_r, hw_nxt, hw_eff;
  logic [63:0] asm_r, asm_nxt, asm_eff, asm_new;
  logic [31:0] held_r [3];
  logic [31:0] held_nxt [3];
  logic [31:0] objcnt_r, objcnt_nxt;
  logic [31:0] sectot_r, sectot_nxt;
  logic [31:0] secdone_r, secdone_nxt, secdone_eff;
  logic [31:0] skip_r, skip_nxt, skip_eff;
  logic [31:0] objnum_r, objnum_nxt, objnum_eff;
  logic [63:0] sync_word_r;

  logic        start, four_byte, word_done;
  logic [31:0] w, len, secdone_inc, objnum_inc, skip_dec;
  logic        fin_last, obj_last, skip_last, sync_ok;
  logic        is_pt, is_side, is_skip_type, obj_zero, len_zero, tot_zero;
  logic        fin, end_frame;

  assign start       = in_acc && in_frame_start;
  assign phase_eff   = start ? PH_SYNC : phase_r;
  assign bp_eff      = start ? 3'd0 : bp_r;
  assign hw_eff      = start ? 4'd0 : hw_r;
  assign asm_eff     = start ? 64'd0 : asm_r;
  assign secdone_eff = start ? 32'd0 : secdone_r;
  assign objnum_eff  = start ? 32'd0 : objnum_r;
  assign skip_eff    = start ? 32'd0 : skip_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      asm_new[8*i +: 8] = asm_eff[8*i +: 8] | ((bp_eff == 3'(i)) ? in_data_byte : 8'h00);
    end
  end

  assign four_byte   = (phase_eff == PH_HEADER) || (phase_eff == PH_POINT) ||
                       (phase_eff == PH_SIDE);
  assign word_done   = four_byte ? (bp_eff == WORD_LAST_BYTE) : (bp_eff == DWORD_LAST_BYTE);
  assign w           = asm_new[31:0];
  assign len         = asm_new[63:32];
  assign secdone_inc = secdone_eff + 32'd1;
  assign objnum_inc  = objnum_eff + 32'd1;
  assign skip_dec    = skip_eff - 32'd1;
  assign fin_last    = (secdone_inc == sectot_r);
  assign obj_last    = (objnum_inc == objcnt_r);
  assign skip_last   = (skip_dec == 32'd0);
  assign sync_ok     = (asm_new == sync_word_r);
  assign is_pt       = (w == SEC_POINTS);
  assign is_side     = (w == SEC_SIDE_INFO);
  assign is_skip_type = (w == SEC_SKIP_A) || (w == SEC_SKIP_B) || (w == SEC_SKIP_C);
  assign obj_zero    = (objcnt_r == 32'd0);
  assign len_zero    = (len == 32'd0);
  assign tot_zero    = (sectot_r == 32'd0);

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      phase_nxt = phase_eff;
      unique case (phase_eff)
        PH_SYNC: begin
          if (word_done) begin
            phase_nxt = sync_ok ? PH_HEADER : PH_IDLE;
          end
        end
        PH_HEADER: begin
          if (word_done && hw_eff == HDR_LAST_WORD) begin
            phase_nxt = tot_zero ? PH_IDLE : PH_SECHDR;
          end
        end
        PH_SECHDR: begin
          if (word_done) begin
            if (is_pt || is_side) begin
              if (obj_zero) begin
                phase_nxt = fin_last ? PH_IDLE : PH_SECHDR;
              end else begin
                phase_nxt = is_pt ? PH_POINT : PH_SIDE;
              end
            end else if (len_zero) begin
              phase_nxt = fin_last ? PH_IDLE : PH_SECHDR;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_POINT: begin
          if (word_done && hw_eff == POINT_LAST_WORD && obj_last) begin
            phase_nxt = fin_last ? PH_IDLE : PH_SECHDR;
          end
        end
        PH_SIDE: begin
          if (word_done && obj_last) begin
            phase_nxt = fin_last ? PH_IDLE : PH_SECHDR;
          end
        end
        PH_SKIP: begin
          if (skip_last) begin
            phase_nxt = fin_last ? PH_IDLE : PH_SECHDR;
          end
        end
        PH_IDLE: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Datapath updates and result generation.
  always_comb begin
    bp_nxt      = bp_eff;
    hw_nxt      = hw_eff;
    asm_nxt     = asm_eff;
    held_nxt    = held_r;
    objcnt_nxt  = objcnt_r;
    sectot_nxt  = sectot_r;
    secdone_nxt = secdone_eff;
    skip_nxt    = skip_eff;
    objnum_nxt  = objnum_eff;
    push        = '0;
    push.res.kind = KIND_FRAME_END;
    fin         = 1'b0;
    end_frame   = 1'b0;

    if (in_acc) begin
      if (four_byte || phase_eff == PH_SYNC || phase_eff == PH_SECHDR) begin
        if (word_done) begin
          bp_nxt  = 3'd0;
          asm_nxt = 64'd0;
        end else begin
          bp_nxt  = bp_eff + 3'd1;
          asm_nxt = asm_new;
        end
      end

      case (phase_eff)
        PH_SYNC: begin
          if (word_done) begin
            hw_nxt = 4'd0;
            if (!sync_ok) begin
              push.valid       = 1'b1;
              push.res.kind    = KIND_BAD_SYNC;
              push.res.word_a  = asm_new[31:0];
              push.res.word_b  = asm_new[63:32];
              end_frame        = 1'b1;
            end
          end
        end
        PH_HEADER: begin
          if (word_done) begin
            hw_nxt = hw_eff + 4'd1;
            case (hw_eff)
              4'd0:    held_nxt[0] = w;
              4'd1:    held_nxt[1] = w;
              4'd2:    held_nxt[2] = w;
              4'd4:    held_nxt[0] = w;
              4'd5: begin
                held_nxt[1] = w;
                objcnt_nxt  = w;
              end
              4'd6: begin
                held_nxt[2] = w;
                sectot_nxt  = w;
              end
              4'd3, 4'd7: begin
                push.valid      = 1'b1;
                push.res.kind   = (hw_eff == HDR_LAST_WORD) ? KIND_HDR_B : KIND_HDR_A;
                push.res.word_a = held_r[0];
                push.res.word_b = held_r[1];
                push.res.word_c = held_r[2];
                push.res.word_d = w;
                if (hw_eff == HDR_LAST_WORD) begin
                  secdone_nxt = 32'd0;
                  end_frame   = tot_zero;
                end
              end
              default: begin
              end
            endcase
          end
        end
        PH_SECHDR: begin
          if (word_done) begin
            hw_nxt     = 4'd0;
            objnum_nxt = 32'd0;
            if (is_pt || is_side) begin
              fin = obj_zero;
            end else begin
              if (!is_skip_type) begin
                push.valid          = 1'b1;
                push.res.kind       = KIND_UNKNOWN;
                push.res.item_index = secdone_eff;
                push.res.word_a     = w;
                push.res.word_b     = len;
              end
              skip_nxt = len;
              fin      = len_zero;
            end
          end
        end
        PH_POINT: begin
          if (word_done) begin
            if (hw_eff == POINT_LAST_WORD) begin
              push.valid          = 1'b1;
              push.res.kind       = KIND_POINT;
              push.res.item_index = objnum_eff;
              push.res.word_a     = held_r[0];
              push.res.word_b     = held_r[1];
              push.res.word_c     = held_r[2];
              push.res.word_d     = w;
              hw_nxt              = 4'd0;
              objnum_nxt          = objnum_inc;
              fin                 = obj_last;
            end else begin
              for (int i = 0; i < 3; i++) begin
                if (hw_eff == 4'(i)) begin
                  held_nxt[i] = w;
                end
              end
              hw_nxt = hw_eff + 4'd1;
            end
          end
        end
        PH_SIDE: begin
          if (word_done) begin
            push.valid          = 1'b1;
            push.res.kind       = KIND_SIDE;
            push.res.item_index = objnum_eff;
            push.res.word_a     = {16'd0, w[15:0]};
            push.res.word_b     = {16'd0, w[31:16]};
            objnum_nxt          = objnum_inc;
            fin                 = obj_last;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          fin      = skip_last;
        end
        default: begin
        end
      endcase

      if (fin) begin
        secdone_nxt = secdone_inc;
        bp_nxt      = 3'd0;
        asm_nxt     = 64'd0;
        hw_nxt      = 4'd0;
        end_frame   = fin_last;
      end

      if (end_frame) begin
        push.valid             = 1'b1;
        push.res.last_in_frame = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      bp_r        <= '0;
      hw_r        <= '0;
      asm_r       <= '0;
      objcnt_r    <= '0;
      sectot_r    <= '0;
      secdone_r   <= '0;
      skip_r      <= '0;
      objnum_r    <= '0;
      sync_word_r <= SYNC_WORD_RESET;
    end else begin
      phase_r   <= phase_nxt;
      bp_r      <= bp_nxt;
      hw_r      <= hw_nxt;
      asm_r     <= asm_nxt;
      objcnt_r  <= objcnt_nxt;
      sectot_r  <= sectot_nxt;
      secdone_r <= secdone_nxt;
      skip_r    <= skip_nxt;
      objnum_r  <= objnum_nxt;
      if (cfg_we) begin
        sync_word_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfp_queue.sv =====
// ----------------------------------------------------------------------------
// Radar TLV frame parser result queue
// A short first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_queue
  import tfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  push_t      push,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output result_t    head
);

  result_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfp_back.sv =====
// ----------------------------------------------------------------------------
// Radar TLV frame parser output stage
// Pops results from the queue into the output register and hands them on.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_back
  import tfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  result_t    q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign q_pop     = !q_empty && (!valid_r || out_ready);
  assign valid_nxt = q_pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_head;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/radar_tlv_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Radar TLV frame parser
// Parses a byte stream of sync word, header and TLV sections into results.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while its input ready is high and
// does all of its work for a byte in that cycle; a byte yields at most one
// result word. Results pass through a four-entry queue and then an output
// register on their way to the output channel. The input ready drops only
// when the queue is full because the output side is stalled.
// The sync word register may be written only while no bytes are in flight.
`default_nettype none

module radar_tlv_frame_parser_unit
  import tfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  tfp_in_if.sink           in_chan,
  tfp_out_if.source        out_chan
);

  push_t   push;
  result_t q_head, out_res;
  logic    q_full, q_empty, q_pop, in_acc;

  assign in_chan.ready = !q_full;
  assign in_acc        = in_chan.valid && !q_full;

  tfp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_chan.valid),
    .in_data_byte   (in_chan.data_byte),
    .in_frame_start (in_chan.frame_start),
    .in_acc         (in_acc),
    .push           (push)
  );

  tfp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  tfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.kind          = out_res.kind;
  assign out_chan.item_index    = out_res.item_index;
  assign out_chan.word_a        = out_res.word_a;
  assign out_chan.word_b        = out_res.word_b;
  assign out_chan.word_c        = out_res.word_c;
  assign out_chan.word_d        = out_res.word_d;
  assign out_chan.last_in_frame = out_res.last_in_frame;

endmodule

`default_nettype wire
